/* sv/uvs_pkg.sv */
// shared types, constants and a rounding helper function of the uv sphere vertex generator
package uvs_pkg;

    localparam int SINE_TABLE_DEPTH = 256;
    localparam int MAX_DIVISIONS    = 255;

    // pi/2 in Q2.30, seed of the sine table series
    localparam longint PI_HALF_Q30 = 64'sd1686629713;

    // denominators n*(n-1) of the odd taylor terms, n = 3, 5, .. 15
    localparam int     TAYLOR_TERMS = 7;
    localparam longint TAYLOR_DIV [TAYLOR_TERMS] = '{6, 20, 42, 72, 110, 156, 210};

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // 1.0 in Q1.16 for texture saturation
    localparam logic [16:0] TEX_ONE = 17'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RADIUS       = 3'd0,
        REG_SECTOR_COUNT = 3'd1,
        REG_STACK_COUNT  = 3'd2,
        REG_U_STEP       = 3'd3,
        REG_V_STEP       = 3'd4,
        REG_CENTER_X     = 3'd5,
        REG_CENTER_Y     = 3'd6,
        REG_CENTER_Z     = 3'd7
    } t_cfg_reg;

    typedef struct packed {
        logic        [15:0] radius;
        logic        [7:0]  sector_count;
        logic        [7:0]  stack_count;
        logic        [16:0] u_step;
        logic        [16:0] v_step;
        logic signed [15:0] center_x;
        logic signed [15:0] center_y;
        logic signed [15:0] center_z;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{
        radius:       16'd256,
        sector_count: 8'd36,
        stack_count:  8'd18,
        u_step:       17'd1820,
        v_step:       17'd3641,
        center_x:     16'sd0,
        center_y:     16'sd0,
        center_z:     16'sd0
    };

    // per-vertex fields that ride along the position pipeline
    typedef struct packed {
        logic [16:0] tex_u;
        logic [16:0] tex_v;
        logic [15:0] top_corner;
        logic [15:0] bottom_corner;
        logic        upper_tri_valid;
        logic        lower_tri_valid;
        logic        in_range;
    } t_meta;

    // Q1.16 signed sines, -65536 .. 65536
    typedef struct packed {
        logic signed [17:0] sin_stack;
        logic signed [17:0] cos_stack;
        logic signed [17:0] sin_sector;
        logic signed [17:0] cos_sector;
    } t_trig;

    // divide by 65536, round to nearest, ties away from zero
    function automatic logic signed [19:0] rnd16(input logic signed [35:0] val);
        logic [35:0] mag;
        logic [36:0] sum;
        logic [19:0] quo;
        mag = val[35] ? 36'(-val) : 36'(val);
        sum = {1'b0, mag} + 37'd32768;
        quo = sum[35:16];
        return val[35] ? -$signed(quo) : $signed(quo);
    endfunction

endpackage

/* sv/uvs_if.sv */
// valid/ready channels of the uv sphere vertex generator

interface uvs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] stack_index;
    logic [7:0] sector_index;

    modport source (output valid, stack_index, sector_index, input ready);
    modport sink   (input valid, stack_index, sector_index, output ready);
endinterface

interface uvs_out_if;
    logic               valid;
    logic               ready;
    logic signed [17:0] pos_x;
    logic signed [17:0] pos_y;
    logic signed [17:0] pos_z;
    logic        [16:0] tex_u;
    logic        [16:0] tex_v;
    logic        [15:0] top_corner;
    logic        [15:0] bottom_corner;
    logic               upper_tri_valid;
    logic               lower_tri_valid;
    logic               in_range;

    modport source (output valid, pos_x, pos_y, pos_z, tex_u, tex_v, top_corner,
                    bottom_corner, upper_tri_valid, lower_tri_valid, in_range,
                    input ready);
    modport sink   (input valid, pos_x, pos_y, pos_z, tex_u, tex_v, top_corner,
                    bottom_corner, upper_tri_valid, lower_tri_valid, in_range,
                    output ready);
endinterface

interface uvs_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [uvs_pkg::CFG_IDX_W-1:0]     index;
    logic [uvs_pkg::CFG_DATA_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

/* sv/uv_sphere_vertex_generator_unit.sv */
// top level of the uv sphere vertex generator: six-stage vertex pipeline
//
//   channel  dir  signals                                   transfer when
//   i_in     in   stack_index, sector_index                 valid && ready
//   o_out    out  pos_x/y/z, tex_u/v, corners, tri marks    valid && ready
//   i_cfg    in   index (3 bits), data (17 bits)            valid && ready
//
// one vertex per cycle sustained while o_out is ready
// the stages are the index stage and the sine table stage, then two dependent multiply
// levels (radius, then sector), each followed by a rounding stage
// reset clears the valid bits and loads the register defaults; no clearing pass
// each stage holds when it is full and the next one cannot take its data, so a
// stall at o_out fills bubbles first and only then blocks i_in; i_cfg is always ready
module uv_sphere_vertex_generator_unit #(
    parameter int SINE_TABLE_DEPTH = uvs_pkg::SINE_TABLE_DEPTH,
    parameter int MAX_DIVISIONS    = uvs_pkg::MAX_DIVISIONS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    uvs_in_if.sink     i_in,
    uvs_out_if.source  o_out,
    uvs_cfg_if.sink    i_cfg
);

    localparam int Stages = 6;

    uvs_pkg::t_cfg  cfg;
    uvs_pkg::t_meta grid_meta;
    uvs_pkg::t_meta trig_meta;
    uvs_pkg::t_trig trig;
    uvs_pkg::t_meta out_meta;

    logic [Stages:1] r_vld;
    logic [Stages:1] n_vld;
    logic [Stages:1] stage_en;

    // per-stage load enable: a stage loads when empty or when its data moves on
    always_comb begin
        stage_en[Stages] = !r_vld[Stages] || o_out.ready;
        for (int k = Stages - 1; k >= 1; k--) begin
            stage_en[k] = !r_vld[k] || stage_en[k + 1];
        end
    end

    always_comb begin
        n_vld = r_vld;
        if (stage_en[1]) begin
            n_vld[1] = i_in.valid;
        end
        for (int k = 2; k <= Stages; k++) begin
            if (stage_en[k]) begin
                n_vld[k] = r_vld[k - 1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign i_in.ready  = stage_en[1];
    assign o_out.valid = r_vld[Stages];

    uvs_cfg_regs u_cfg_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (cfg)
    );

    // stage 1: texture coordinates, corners, triangle marks
    uvs_grid_stage #(
        .MAX_DIVISIONS (MAX_DIVISIONS)
    ) u_grid_stage (
        .i_clk          (i_clk),
        .i_en           (stage_en[1]),
        .i_stack_index  (i_in.stack_index),
        .i_sector_index (i_in.sector_index),
        .i_cfg          (cfg),
        .o_meta         (grid_meta)
    );

    // stage 2: phases and sine table
    uvs_trig_stage #(
        .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
    ) u_trig_stage (
        .i_clk  (i_clk),
        .i_en   (stage_en[2]),
        .i_meta (grid_meta),
        .o_meta (trig_meta),
        .o_trig (trig)
    );

    // stages 3 to 6: position arithmetic and output register
    uvs_pos_stages u_pos_stages (
        .i_clk   (i_clk),
        .i_en    (stage_en[Stages:3]),
        .i_cfg   (cfg),
        .i_meta  (trig_meta),
        .i_trig  (trig),
        .o_meta  (out_meta),
        .o_pos_x (o_out.pos_x),
        .o_pos_y (o_out.pos_y),
        .o_pos_z (o_out.pos_z)
    );

    assign o_out.tex_u           = out_meta.tex_u;
    assign o_out.tex_v           = out_meta.tex_v;
    assign o_out.top_corner      = out_meta.top_corner;
    assign o_out.bottom_corner   = out_meta.bottom_corner;
    assign o_out.upper_tri_valid = out_meta.upper_tri_valid;
    assign o_out.lower_tri_valid = out_meta.lower_tri_valid;
    assign o_out.in_range        = out_meta.in_range;

    // an out-of-range grid index never carries a triangle
    a_no_tri_out_of_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid && !o_out.in_range |-> !o_out.upper_tri_valid && !o_out.lower_tri_valid)
        else $error("triangle mark set on out-of-range vertex");

    // texture coordinates are saturated at 1.0
    a_tex_saturated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.tex_u <= uvs_pkg::TEX_ONE && o_out.tex_v <= uvs_pkg::TEX_ONE)
        else $error("texture coordinate above 1.0");

    // a full pipeline blocked at the output refuses new input
    a_full_stall_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (&r_vld) && !o_out.ready |-> !i_in.ready)
        else $error("input taken while pipeline is full and stalled");

    // an accepted input always lands in the first stage
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in.valid && i_in.ready |=> r_vld[1])
        else $error("accepted input lost at first stage");

    // the bottom corner is one full ring after the top corner, never the same index
    a_corner_stride: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> o_out.bottom_corner != o_out.top_corner)
        else $error("bottom corner equals top corner");

endmodule

/* sv/uvs_cfg_regs.sv */
// configuration register file of the uv sphere vertex generator
module uvs_cfg_regs (
    input  logic          i_clk,
    input  logic          i_rst_n,
    uvs_cfg_if.sink       i_cfg,
    output uvs_pkg::t_cfg o_cfg
);

    uvs_pkg::t_cfg r_cfg;
    uvs_pkg::t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (uvs_pkg::t_cfg_reg'(i_cfg.index))
                uvs_pkg::REG_RADIUS:       n_cfg.radius       = i_cfg.data[15:0];
                uvs_pkg::REG_SECTOR_COUNT: n_cfg.sector_count = i_cfg.data[7:0];
                uvs_pkg::REG_STACK_COUNT:  n_cfg.stack_count  = i_cfg.data[7:0];
                uvs_pkg::REG_U_STEP:       n_cfg.u_step       = i_cfg.data[16:0];
                uvs_pkg::REG_V_STEP:       n_cfg.v_step       = i_cfg.data[16:0];
                uvs_pkg::REG_CENTER_X:     n_cfg.center_x     = $signed(i_cfg.data[15:0]);
                uvs_pkg::REG_CENTER_Y:     n_cfg.center_y     = $signed(i_cfg.data[15:0]);
                uvs_pkg::REG_CENTER_Z:     n_cfg.center_z     = $signed(i_cfg.data[15:0]);
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= uvs_pkg::CFG_RESET;
        end else begin
            r_cfg <= n_cfg;
        end
    end

endmodule

/* sv/uvs_grid_stage.sv */
// first stage: texture coordinates, corner indices and triangle marks
module uvs_grid_stage #(
    parameter int MAX_DIVISIONS = uvs_pkg::MAX_DIVISIONS
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [7:0]     i_stack_index,
    input  logic [7:0]     i_sector_index,
    input  uvs_pkg::t_cfg  i_cfg,
    output uvs_pkg::t_meta o_meta
);

    localparam logic [7:0] DivLimit = 8'(MAX_DIVISIONS);

    uvs_pkg::t_meta r_meta;
    uvs_pkg::t_meta n_meta;

    logic [7:0]  sec_lim;
    logic [7:0]  stk_lim;
    logic [8:0]  stride;
    logic [24:0] u_prod;
    logic [24:0] v_prod;
    logic [16:0] row_base;
    logic [16:0] top_full;
    logic [16:0] bot_full;
    logic        owns_quad;

    always_comb begin
        sec_lim = (i_cfg.sector_count > DivLimit) ? DivLimit : i_cfg.sector_count;
        stk_lim = (i_cfg.stack_count  > DivLimit) ? DivLimit : i_cfg.stack_count;
        stride  = {1'b0, sec_lim} + 9'd1;

        u_prod = 25'(i_sector_index) * 25'(i_cfg.u_step);
        v_prod = 25'(i_stack_index)  * 25'(i_cfg.v_step);

        // rings are stride apart, corners wrap at 16 bits
        row_base = 17'(i_stack_index) * 17'(stride);
        top_full = row_base + 17'(i_sector_index);
        bot_full = top_full + 17'(stride);

        owns_quad = (i_stack_index < stk_lim) && (i_sector_index < sec_lim);

        n_meta.tex_u = (u_prod > 25'(uvs_pkg::TEX_ONE)) ? uvs_pkg::TEX_ONE : u_prod[16:0];
        n_meta.tex_v = (v_prod > 25'(uvs_pkg::TEX_ONE)) ? uvs_pkg::TEX_ONE : v_prod[16:0];
        n_meta.top_corner      = top_full[15:0];
        n_meta.bottom_corner   = bot_full[15:0];
        n_meta.upper_tri_valid = owns_quad && (i_stack_index != 8'd0);
        n_meta.lower_tri_valid = owns_quad && (({1'b0, i_stack_index} + 9'd1) != {1'b0, stk_lim});
        n_meta.in_range        = (i_stack_index <= stk_lim) && (i_sector_index <= sec_lim);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_meta <= n_meta;
        end
    end

    assign o_meta = r_meta;

endmodule

/* sv/uvs_trig_stage.sv */
// second stage: stack and sector phases and four quarter-wave table lookups
module uvs_trig_stage #(
    parameter int SINE_TABLE_DEPTH = uvs_pkg::SINE_TABLE_DEPTH
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  uvs_pkg::t_meta i_meta,
    output uvs_pkg::t_meta o_meta,
    output uvs_pkg::t_trig o_trig
);

    localparam int IdxW  = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int ProdW = IdxW + 15;

    typedef logic [16:0] t_rom [SINE_TABLE_DEPTH + 1];

    // quarter-wave sine, Q1.16, integer taylor series in Q2.30
    function automatic t_rom build_rom();
        t_rom   rom;
        longint x;
        longint x2;
        longint term;
        longint sum;
        for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
            x    = (uvs_pkg::PI_HALF_Q30 * longint'(k) + longint'(SINE_TABLE_DEPTH / 2))
                   / SINE_TABLE_DEPTH;
            x2   = (x * x) >>> 30;
            term = x;
            sum  = x;
            for (int i = 0; i < uvs_pkg::TAYLOR_TERMS; i++) begin
                term = ((term * x2) >>> 30) / uvs_pkg::TAYLOR_DIV[i];
                if (!i[0]) begin
                    sum = sum - term;
                end else begin
                    sum = sum + term;
                end
            end
            if (sum < 0) begin
                sum = 0;
            end
            sum = (sum + 8192) >>> 14;
            if (sum > 65536) begin
                sum = 65536;
            end
            rom[k] = 17'(sum);
        end
        return rom;
    endfunction

    localparam t_rom SineRom = build_rom();

    function automatic logic signed [17:0] sin_lookup(input logic [15:0] phase);
        logic [1:0]       quad;
        logic [14:0]      ofs;
        logic [ProdW-1:0] prod;
        logic [IdxW:0]    idx_full;
        logic [IdxW-1:0]  idx;
        logic [16:0]      mag;
        quad = phase[15:14];
        // mirror the offset in the odd quadrants
        ofs  = quad[0] ? (15'd16384 - {1'b0, phase[13:0]}) : {1'b0, phase[13:0]};
        prod = ProdW'(ofs) * ProdW'(SINE_TABLE_DEPTH) + ProdW'(8192);
        idx_full = prod[ProdW-1:14];
        idx  = (idx_full > (IdxW + 1)'(SINE_TABLE_DEPTH)) ? IdxW'(SINE_TABLE_DEPTH)
                                                          : idx_full[IdxW-1:0];
        mag  = SineRom[idx];
        return quad[1] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    endfunction

    uvs_pkg::t_meta r_meta;
    uvs_pkg::t_trig r_trig;
    uvs_pkg::t_trig n_trig;
    logic [15:0]    ph_stack;
    logic [15:0]    ph_sector;

    always_comb begin
        // stack angle = 90 deg - pi * v, i.e. a quarter turn minus v/2
        ph_stack  = 16'(17'd16384 - {1'b0, i_meta.tex_v[16:1]});
        ph_sector = i_meta.tex_u[15:0];

        n_trig.sin_stack  = sin_lookup(ph_stack);
        n_trig.cos_stack  = sin_lookup(ph_stack + 16'd16384);
        n_trig.sin_sector = sin_lookup(ph_sector);
        n_trig.cos_sector = sin_lookup(ph_sector + 16'd16384);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_meta <= i_meta;
            r_trig <= n_trig;
        end
    end

    assign o_meta = r_meta;
    assign o_trig = r_trig;

endmodule

/* sv/uvs_pos_stages.sv */
// stages three to six: radius products, rounding, sector products, center offset
module uvs_pos_stages (
    input  logic               i_clk,
    input  logic [3:0]         i_en,
    input  uvs_pkg::t_cfg      i_cfg,
    input  uvs_pkg::t_meta     i_meta,
    input  uvs_pkg::t_trig     i_trig,
    output uvs_pkg::t_meta     o_meta,
    output logic signed [17:0] o_pos_x,
    output logic signed [17:0] o_pos_y,
    output logic signed [17:0] o_pos_z
);

    // stage 3: radius times stack cosine and sine
    uvs_pkg::t_meta     r3_meta;
    logic signed [35:0] r3_proj_prod;
    logic signed [35:0] r3_z_prod;
    logic signed [17:0] r3_sin_sector;
    logic signed [17:0] r3_cos_sector;
    logic signed [35:0] n3_proj_prod;
    logic signed [35:0] n3_z_prod;

    // stage 4: rounded ring radius and finished z
    uvs_pkg::t_meta     r4_meta;
    logic signed [17:0] r4_proj;
    logic signed [17:0] r4_z;
    logic signed [17:0] r4_sin_sector;
    logic signed [17:0] r4_cos_sector;
    logic signed [19:0] n4_proj;
    logic signed [19:0] n4_z;

    // stage 5: ring radius times sector cosine and sine
    uvs_pkg::t_meta     r5_meta;
    logic signed [35:0] r5_x_prod;
    logic signed [35:0] r5_y_prod;
    logic signed [17:0] r5_z;
    logic signed [35:0] n5_x_prod;
    logic signed [35:0] n5_y_prod;

    // stage 6: output register
    uvs_pkg::t_meta     r6_meta;
    logic signed [17:0] r6_x;
    logic signed [17:0] r6_y;
    logic signed [17:0] r6_z;
    logic signed [19:0] n6_x;
    logic signed [19:0] n6_y;

    always_comb begin
        n3_proj_prod = $signed({1'b0, i_cfg.radius}) * i_trig.cos_stack;
        n3_z_prod    = $signed({1'b0, i_cfg.radius}) * i_trig.sin_stack;

        n4_proj = uvs_pkg::rnd16(r3_proj_prod);
        n4_z    = uvs_pkg::rnd16(r3_z_prod) + 20'(i_cfg.center_z);

        n5_x_prod = r4_proj * r4_cos_sector;
        n5_y_prod = r4_proj * r4_sin_sector;

        n6_x = uvs_pkg::rnd16(r5_x_prod) + 20'(i_cfg.center_x);
        n6_y = uvs_pkg::rnd16(r5_y_prod) + 20'(i_cfg.center_y);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r3_meta       <= i_meta;
            r3_proj_prod  <= n3_proj_prod;
            r3_z_prod     <= n3_z_prod;
            r3_sin_sector <= i_trig.sin_sector;
            r3_cos_sector <= i_trig.cos_sector;
        end
        if (i_en[1]) begin
            r4_meta       <= r3_meta;
            r4_proj       <= n4_proj[17:0];
            r4_z          <= n4_z[17:0];
            r4_sin_sector <= r3_sin_sector;
            r4_cos_sector <= r3_cos_sector;
        end
        if (i_en[2]) begin
            r5_meta   <= r4_meta;
            r5_x_prod <= n5_x_prod;
            r5_y_prod <= n5_y_prod;
            r5_z      <= r4_z;
        end
        if (i_en[3]) begin
            r6_meta <= r5_meta;
            r6_x    <= n6_x[17:0];
            r6_y    <= n6_y[17:0];
            r6_z    <= r5_z;
        end
    end

    assign o_meta  = r6_meta;
    assign o_pos_x = r6_x;
    assign o_pos_y = r6_y;
    assign o_pos_z = r6_z;

endmodule
